// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; every property is sampled on the rising edge of clock
// and held off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in every cycle.
`define ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Cause in one cycle, effect in the next.
`define ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

// ===== hw/rtl/u16s_pkg.sv =====
package u16s_pkg;

   localparam int DATA_W       = 16;
   localparam int CAPACITY_DEF = 64;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic cap_in;      // latch the accepted beat
      logic ovf_set;     // mark the current set as having lost values
      logic seek_start;  // start the insertion point at the fill count
      logic rd_seek;     // read the entry below the insertion point
      logic step_shift;  // move the read entry up one place
      logic place;       // write the new value at the insertion point
      logic out_start;   // rewind the output index
      logic rd_out;      // read the entry at the output index
      logic load_out;    // load the result register
      logic out_next;    // advance the output index
      logic clear_set;   // drop fill count and overflow mark
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic full;        // store holds CAPACITY values
      logic j_zero;      // insertion point at the bottom
      logic greater;     // read entry is above the new value
      logic item_last;   // latched beat closes the set
      logic out_last;    // result register holds the final value
   } stat_type;

endpackage

// ===== hw/rtl/uint16_array_sorter.sv =====
// Sorts sets of unsigned 16-bit values into ascending order. Send a set one
// value per beat on the req_ side and mark its final beat with req_tlast; the
// block then returns the whole set on the rsp_ side, smallest first, one value
// per beat, with rsp_tlast on the final one. Duplicates come back as often as
// they arrived. The store holds CAPACITY values; further values of a set are
// dropped, and every result beat of that set then carries rsp_tuser = 1.
// Each value is inserted into a sorted single-port-read memory as it arrives:
// every stored value greater than the new one is read and moved up one place,
// then the new value is written at the insertion point, and req_tready stays
// low meanwhile. A dropped beat is not written. Each result is read from the
// memory into a register and then loaded into the output register; the next
// read starts only once rsp_tready has taken the beat. No clearing pass follows
// reset: a fill count marks the valid entries, so the block accepts beats
// straight after reset.
`include "assert_macros.svh"

module uint16_array_sorter #(
   parameter int CAPACITY = u16s_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // input set
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic        req_tlast,   // last
   // sorted results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] sorted_value
   output logic        rsp_tlast,   // last_out
   output logic        rsp_tuser    // [0] overflow
);

   u16s_pkg::cmd_type  cmd;
   u16s_pkg::stat_type stat;

   // sequencing of insertion and readout
   u16s_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // store, insertion pointer, fill count and result register
   u16s_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_value  (req_tdata),
      .in_last   (req_tlast),
      .out_value (rsp_tdata),
      .out_last  (rsp_tlast),
      .out_ovf   (rsp_tuser)
   );

   // Input and output sides never run at once
   `ASSERT_ALWAYS(a_no_overlap, !(req_tready && rsp_tvalid), "input open during readout")
   // Closing result beat hands control straight back to the input side
   `ASSERT_NEXT(a_close_to_idle, rsp_tvalid && rsp_tready && rsp_tlast, req_tready, "not closed")
   // One memory write at a time: shift and placement exclude each other
   `ASSERT_ALWAYS(a_one_write, !(cmd.place && cmd.step_shift), "shift and place at once")
   // Overflow is only raised on a full store
   `ASSERT_ALWAYS(a_ovf_full, !cmd.ovf_set || stat.full, "overflow marked with room left")

endmodule

// ===== hw/rtl/u16s_dp.sv =====
module u16s_dp #(
   parameter int CAPACITY = u16s_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  u16s_pkg::cmd_type            cmd,
   output u16s_pkg::stat_type           stat,
   input  logic [u16s_pkg::DATA_W-1:0]  in_value,
   input  logic                         in_last,
   output logic [u16s_pkg::DATA_W-1:0]  out_value,
   output logic                         out_last,
   output logic                         out_ovf
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [u16s_pkg::DATA_W-1:0] mem [CAPACITY];

   logic [u16s_pkg::DATA_W-1:0] v_ff, v_in;
   logic                        last_ff, last_in;
   logic [IDX_W-1:0]            j_ff, j_in;
   logic [IDX_W-1:0]            k_ff, k_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic [u16s_pkg::DATA_W-1:0] rdata_ff;
   logic [u16s_pkg::DATA_W-1:0] oval_ff, oval_in;
   logic                        olast_ff, olast_in;
   logic                        oovf_ff, oovf_in;

   logic [IDX_W-1:0]            rd_addr;
   logic                        wr_en;
   logic [u16s_pkg::DATA_W-1:0] wr_data;
   logic                        k_is_final;

   assign rd_addr = cmd.rd_seek ? (j_ff - IDX_W'(1)) : k_ff;
   assign wr_en   = cmd.step_shift | cmd.place;
   assign wr_data = cmd.step_shift ? rdata_ff : v_ff;
   assign k_is_final = (CNT_W'(k_ff) + CNT_W'(1)) == count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[j_ff] <= wr_data;
      end
      if (cmd.rd_seek | cmd.rd_out) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      v_in     = cmd.cap_in ? in_value : v_ff;
      last_in  = cmd.cap_in ? in_last : last_ff;
      j_in     = j_ff;
      if (cmd.seek_start) begin
         j_in = count_ff[IDX_W-1:0];
      end else if (cmd.step_shift) begin
         j_in = j_ff - IDX_W'(1);
      end
      k_in     = k_ff;
      if (cmd.out_start) begin
         k_in = '0;
      end else if (cmd.out_next) begin
         k_in = k_ff + IDX_W'(1);
      end
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.clear_set) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end else begin
         if (cmd.place) begin
            count_in = count_ff + CNT_W'(1);
         end
         if (cmd.ovf_set) begin
            ovf_in = 1'b1;
         end
      end
      oval_in  = cmd.load_out ? rdata_ff : oval_ff;
      olast_in = cmd.load_out ? k_is_final : olast_ff;
      oovf_in  = cmd.load_out ? ovf_ff : oovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
      v_ff     <= v_in;
      last_ff  <= last_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      oval_ff  <= oval_in;
      olast_ff <= olast_in;
      oovf_ff  <= oovf_in;
   end

   assign stat.full      = (count_ff == CNT_W'(CAPACITY));
   assign stat.j_zero    = (j_ff == '0);
   assign stat.greater   = (rdata_ff > v_ff);
   assign stat.item_last = last_ff;
   assign stat.out_last  = olast_ff;

   assign out_value = oval_ff;
   assign out_last  = olast_ff;
   assign out_ovf   = oovf_ff;

endmodule

// ===== hw/rtl/u16s_ctrl.sv =====
module u16s_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  u16s_pkg::stat_type  stat,
   output u16s_pkg::cmd_type   cmd
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SEEK     = 6'b000010,
      S_CMP      = 6'b000100,
      S_OUT_RD   = 6'b001000,
      S_OUT_LD   = 6'b010000,
      S_OUT_WAIT = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.cap_in = 1'b1;
               if (stat.full) begin
                  // drop the beat, keep the set open unless it closes here
                  cmd.ovf_set = 1'b1;
                  if (req_tlast) begin
                     cmd.out_start = 1'b1;
                     state_in      = S_OUT_RD;
                  end
               end else begin
                  cmd.seek_start = 1'b1;
                  state_in       = S_SEEK;
               end
            end
         end
         S_SEEK: begin
            if (stat.j_zero) begin
               cmd.place = 1'b1;
               if (stat.item_last) begin
                  cmd.out_start = 1'b1;
                  state_in      = S_OUT_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               cmd.rd_seek = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.greater) begin
               cmd.step_shift = 1'b1;
               state_in       = S_SEEK;
            end else begin
               cmd.place = 1'b1;
               if (stat.item_last) begin
                  cmd.out_start = 1'b1;
                  state_in      = S_OUT_RD;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_OUT_RD: begin
            cmd.rd_out = 1'b1;
            state_in   = S_OUT_LD;
         end
         S_OUT_LD: begin
            cmd.load_out = 1'b1;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_tready) begin
               if (stat.out_last) begin
                  cmd.clear_set = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.out_next = 1'b1;
                  state_in     = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign rsp_tvalid = (state_ff == S_OUT_WAIT) && !reset;

endmodule
